FILE: sv/hvd_pkg.sv
// Shared constants, types and helpers of the haversine distance pipeline.
package hvd_pkg;

    localparam int ANGLE_FRAC_BITS = 23;
    localparam int LAT_W           = 31;
    localparam int LON_W           = 32;
    localparam int DIST_W          = 25;

    localparam int CORDIC_STEPS = 30;
    localparam int CW           = 34;
    localparam int TRIG_W       = 32;
    localparam int ANG_W        = 32;

    localparam int NUM_W       = 33;
    localparam int SHIFT_HALF  = 31 - ANGLE_FRAC_BITS;
    localparam int SHIFT_FULL  = 32 - ANGLE_FRAC_BITS;
    localparam int N_W         = NUM_W + SHIFT_FULL + 1;
    localparam int M_W         = N_W - 3;
    localparam int M_LO_W      = M_W / 2;
    localparam int M_HI_W      = M_W - M_LO_W;
    localparam int RECIP_W     = M_W - 5;
    localparam int PH_W        = M_HI_W + RECIP_W;
    localparam int Q_W         = M_W - 5;
    localparam int R_W         = 7;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << M_W) / 45);
    localparam logic [N_W-1:0]     ROUND_HALF_TURN = N_W'(180);
    localparam logic [R_W-1:0]     DIV_45 = R_W'(45);

    localparam logic signed [CW-1:0] ONE_Q30  = 34'sd1073741824;
    localparam logic signed [CW-1:0] TWO_Q31  = 34'sd2147483648;
    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

    localparam logic signed [CW-1:0] ATAN_TURN [CORDIC_STEPS] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
        34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
        34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
        34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
        34'sd652,       34'sd326,       34'sd163,       34'sd81,
        34'sd41,        34'sd20,        34'sd10,        34'sd5,
        34'sd3,         34'sd1
    };

    localparam int A_W    = 61;
    localparam int ROOT_W = 31;
    localparam logic [A_W-1:0]     ONE_Q60 = 61'h1000_0000_0000_0000;
    localparam logic signed [63:0] SUM_ONE = 64'sh1000_0000_0000_0000;

    localparam logic [32:0]       PI_R_Q8   = 33'd5125470715;
    localparam logic [63:0]       ROUND_38  = 64'h0000_0020_0000_0000;
    localparam logic [DIST_W-1:0] HALF_CIRC = 25'd20021370;

    typedef struct packed {
        logic en;
        logic vld;
    } hvd_ctl_t;

    function automatic logic signed [CW-1:0] clamp_q30(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        priority if (v > ONE_Q30)
            r = ONE_Q30;
        else if (v < -ONE_Q30)
            r = -ONE_Q30;
        else
            r = v;
        return r;
    endfunction

endpackage

FILE: sv/hvd_points_if.sv
// Input channel: one pair of geographic points per transfer.
interface hvd_points_if;
    logic                              valid;
    logic                              ready;
    logic signed [hvd_pkg::LAT_W-1:0]  first_latitude;
    logic signed [hvd_pkg::LON_W-1:0]  first_longitude;
    logic signed [hvd_pkg::LAT_W-1:0]  second_latitude;
    logic signed [hvd_pkg::LON_W-1:0]  second_longitude;

    modport source (output valid, first_latitude, first_longitude, second_latitude,
                    second_longitude, input ready);
    modport sink   (input valid, first_latitude, first_longitude, second_latitude,
                    second_longitude, output ready);
endinterface

FILE: sv/hvd_distance_if.sv
// Output channel: one distance in meters per transfer.
interface hvd_distance_if;
    logic                         valid;
    logic                         ready;
    logic [hvd_pkg::DIST_W-1:0]   distance_meters;

    modport source (output valid, distance_meters, input ready);
    modport sink   (input valid, distance_meters, output ready);
endinterface

FILE: sv/hvd_sincos.sv
// Pipelined CORDIC sine and cosine of a binary angle, one rotation per stage.
module hvd_sincos (
    input  logic                               clk,
    input  logic                               rst_n,
    input  hvd_pkg::hvd_ctl_t                  ctl,
    input  logic [hvd_pkg::ANG_W-1:0]          ang,
    output logic                               vld_out,
    output logic signed [hvd_pkg::TRIG_W-1:0]  sin_q30,
    output logic signed [hvd_pkg::TRIG_W-1:0]  cos_q30
);

    localparam int STEPS = hvd_pkg::CORDIC_STEPS;
    localparam int CW    = hvd_pkg::CW;

    logic signed [CW-1:0] x_reg [STEPS+1];
    logic signed [CW-1:0] y_reg [STEPS+1];
    logic signed [CW-1:0] z_reg [STEPS+1];
    logic                 flip_reg [STEPS+1];
    logic                 vld_reg [STEPS+1];

    logic signed [CW-1:0] z_in;
    logic signed [CW-1:0] z_fold;
    logic                 flip_in;

    logic signed [CW-1:0]             x_clamp;
    logic signed [CW-1:0]             y_clamp;
    logic signed [CW-1:0]             x_final;
    logic signed [CW-1:0]             y_final;
    logic signed [hvd_pkg::TRIG_W-1:0] sin_reg;
    logic signed [hvd_pkg::TRIG_W-1:0] cos_reg;
    logic                             out_vld_reg;

    assign z_in = {{(CW-hvd_pkg::ANG_W){ang[hvd_pkg::ANG_W-1]}}, ang};

    always_comb
    begin
        priority if (z_in > hvd_pkg::ONE_Q30)
        begin
            z_fold  = z_in - hvd_pkg::TWO_Q31;
            flip_in = 1'b1;
        end
        else if (z_in < -hvd_pkg::ONE_Q30)
        begin
            z_fold  = z_in + hvd_pkg::TWO_Q31;
            flip_in = 1'b1;
        end
        else
        begin
            z_fold  = z_in;
            flip_in = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            x_reg[0]    <= hvd_pkg::GAIN_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_fold;
            flip_reg[0] <= flip_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (ctl.en)
            vld_reg[0] <= ctl.vld;
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic signed [CW-1:0] x_sh;
        logic signed [CW-1:0] y_sh;
        logic signed [CW-1:0] x_nx;
        logic signed [CW-1:0] y_nx;
        logic signed [CW-1:0] z_nx;

        always_comb
        begin
            x_sh = x_reg[i] >>> i;
            y_sh = y_reg[i] >>> i;
            if (!z_reg[i][CW-1])
            begin
                x_nx = x_reg[i] - y_sh;
                y_nx = y_reg[i] + x_sh;
                z_nx = z_reg[i] - hvd_pkg::ATAN_TURN[i];
            end
            else
            begin
                x_nx = x_reg[i] + y_sh;
                y_nx = y_reg[i] - x_sh;
                z_nx = z_reg[i] + hvd_pkg::ATAN_TURN[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                x_reg[i+1]    <= x_nx;
                y_reg[i+1]    <= y_nx;
                z_reg[i+1]    <= z_nx;
                flip_reg[i+1] <= flip_reg[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else if (ctl.en)
                vld_reg[i+1] <= vld_reg[i];
        end
    end

    always_comb
    begin
        x_clamp = hvd_pkg::clamp_q30(x_reg[STEPS]);
        y_clamp = hvd_pkg::clamp_q30(y_reg[STEPS]);
        x_final = flip_reg[STEPS] ? -x_clamp : x_clamp;
        y_final = flip_reg[STEPS] ? -y_clamp : y_clamp;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            cos_reg <= x_final[hvd_pkg::TRIG_W-1:0];
            sin_reg <= y_final[hvd_pkg::TRIG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (ctl.en)
            out_vld_reg <= vld_reg[STEPS];
    end

    assign vld_out = out_vld_reg;
    assign sin_q30 = sin_reg;
    assign cos_q30 = cos_reg;

endmodule

FILE: sv/hvd_sqrt.sv
// Pipelined floor integer square root, one result bit per stage.
module hvd_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hvd_pkg::hvd_ctl_t             ctl,
    input  logic [hvd_pkg::A_W-1:0]       radicand,
    output logic                          vld_out,
    output logic [hvd_pkg::ROOT_W-1:0]    root
);

    localparam int RT = hvd_pkg::ROOT_W;
    localparam int DW = 2 * RT;
    localparam int RW = RT + 3;

    logic [RW-1:0] rem_reg  [RT+1];
    logic [RT-1:0] root_reg [RT+1];
    logic [DW-1:0] dat_reg  [RT+1];
    logic          vld_reg  [RT+1];

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            dat_reg[0]  <= DW'(radicand);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (ctl.en)
            vld_reg[0] <= ctl.vld;
    end

    for (genvar k = 0; k < RT; k++)
    begin : g_bit
        logic [RW-1:0] rem_sh;
        logic [RW-1:0] trial;
        logic [RW-1:0] rem_nx;
        logic [RT-1:0] root_nx;

        always_comb
        begin
            rem_sh = {rem_reg[k][RW-3:0], dat_reg[k][DW-1 -: 2]};
            trial  = RW'({root_reg[k], 2'b01});
            if (rem_sh >= trial)
            begin
                rem_nx  = rem_sh - trial;
                root_nx = {root_reg[k][RT-2:0], 1'b1};
            end
            else
            begin
                rem_nx  = rem_sh;
                root_nx = {root_reg[k][RT-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                rem_reg[k+1]  <= rem_nx;
                root_reg[k+1] <= root_nx;
                dat_reg[k+1]  <= {dat_reg[k][DW-3:0], 2'b00};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (ctl.en)
                vld_reg[k+1] <= vld_reg[k];
        end
    end

    assign vld_out = vld_reg[RT];
    assign root    = root_reg[RT];

endmodule

FILE: sv/haversine_distance.sv
// Top level of the haversine great-circle distance pipeline.
//
// Takes one pair of points per cycle, unless the output is stalled, and returns the
// great-circle distance in whole meters on a sphere of radius 6373000 m, saturated at
// the half circumference (20021370 m). The pipeline consists of the angle conversion
// (6 stages), the rotation CORDIC for sine and cosine (32), the product tree (5), the
// bit-per-stage square root (32), the vectoring CORDIC (31) and the scaling (3). When
// the output is not taken the whole pipeline holds; nothing is lost or repeated.
module haversine_distance (
    input  logic                   clk,
    input  logic                   rst_n,
    hvd_points_if.sink             points,
    hvd_distance_if.source         distance
);

    localparam int NUM_W  = hvd_pkg::NUM_W;
    localparam int N_W    = hvd_pkg::N_W;
    localparam int M_W    = hvd_pkg::M_W;
    localparam int PH_W   = hvd_pkg::PH_W;
    localparam int Q_W    = hvd_pkg::Q_W;
    localparam int R_W    = hvd_pkg::R_W;
    localparam int CW     = hvd_pkg::CW;
    localparam int TW     = hvd_pkg::TRIG_W;
    localparam int A_W    = hvd_pkg::A_W;
    localparam int RT     = hvd_pkg::ROOT_W;
    localparam int STEPS  = hvd_pkg::CORDIC_STEPS;
    localparam int ANG_W  = hvd_pkg::ANG_W;
    localparam int NCH    = 4;

    logic en;
    logic out_vld_reg;

    assign en           = !out_vld_reg || distance.ready;
    assign points.ready = en;

    // input capture
    logic signed [hvd_pkg::LAT_W-1:0] lat1_reg;
    logic signed [hvd_pkg::LON_W-1:0] lon1_reg;
    logic signed [hvd_pkg::LAT_W-1:0] lat2_reg;
    logic signed [hvd_pkg::LON_W-1:0] lon2_reg;
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lat1_reg <= points.first_latitude;
            lon1_reg <= points.first_longitude;
            lat2_reg <= points.second_latitude;
            lon2_reg <= points.second_longitude;
        end
    end

    // degrees to binary angle: round(mag * 2^s / 360), then sign
    logic signed [NUM_W-1:0] num [NCH];
    logic [M_W-1:0]   m1_reg  [NCH];
    logic             neg1_reg [NCH];
    logic [PH_W-1:0]  phi_reg [NCH];
    logic [PH_W-1:0]  plo_reg [NCH];
    logic [M_W-1:0]   m2_reg  [NCH];
    logic             neg2_reg [NCH];
    logic [Q_W-1:0]   q3_reg  [NCH];
    logic [M_W-1:0]   m3_reg  [NCH];
    logic             neg3_reg [NCH];
    logic [Q_W-1:0]   q4_reg  [NCH];
    logic [R_W-1:0]   r4_reg  [NCH];
    logic             neg4_reg [NCH];
    logic [ANG_W-1:0] ang_reg [NCH];

    assign num[0] = NUM_W'(lat2_reg) - NUM_W'(lat1_reg);
    assign num[1] = NUM_W'(lon2_reg) - NUM_W'(lon1_reg);
    assign num[2] = NUM_W'(lat1_reg);
    assign num[3] = NUM_W'(lat2_reg);

    for (genvar ch = 0; ch < NCH; ch++)
    begin : g_turn
        localparam int SH = (ch < 2) ? hvd_pkg::SHIFT_HALF : hvd_pkg::SHIFT_FULL;

        logic [NUM_W-1:0]  mag;
        logic [N_W-1:0]    scaled;
        logic [PH_W:0]     qsum;
        logic [ANG_W-1:0]  q_lo;

        always_comb
        begin
            mag    = num[ch][NUM_W-1] ? NUM_W'(-num[ch]) : NUM_W'(num[ch]);
            scaled = (N_W'(mag) << SH) + hvd_pkg::ROUND_HALF_TURN;
            qsum   = (PH_W+1)'(phi_reg[ch]) + (PH_W+1)'(plo_reg[ch] >> hvd_pkg::M_LO_W);
            q_lo   = q4_reg[ch][ANG_W-1:0] + ANG_W'(r4_reg[ch] >= hvd_pkg::DIV_45);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m1_reg[ch]   <= scaled[N_W-1:3];
                neg1_reg[ch] <= num[ch][NUM_W-1];

                phi_reg[ch]  <= m1_reg[ch][M_W-1:hvd_pkg::M_LO_W] * hvd_pkg::RECIP;
                plo_reg[ch]  <= m1_reg[ch][hvd_pkg::M_LO_W-1:0] * hvd_pkg::RECIP;
                m2_reg[ch]   <= m1_reg[ch];
                neg2_reg[ch] <= neg1_reg[ch];

                q3_reg[ch]   <= qsum[hvd_pkg::M_HI_W +: Q_W];
                m3_reg[ch]   <= m2_reg[ch];
                neg3_reg[ch] <= neg2_reg[ch];

                r4_reg[ch]   <= m3_reg[ch][R_W-1:0]
                                - R_W'(q3_reg[ch][R_W-1:0] * hvd_pkg::DIV_45);
                q4_reg[ch]   <= q3_reg[ch];
                neg4_reg[ch] <= neg3_reg[ch];

                ang_reg[ch]  <= neg4_reg[ch] ? (ANG_W'(0) - q_lo) : q_lo;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= points.valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // sine of the half differences, cosine of the latitudes
    hvd_pkg::hvd_ctl_t     sc_ctl;
    logic                  sc_vld;
    logic signed [TW-1:0]  slat;
    logic signed [TW-1:0]  slon;
    logic signed [TW-1:0]  c1;
    logic signed [TW-1:0]  c2;

    assign sc_ctl = '{en: en, vld: v5_reg};

    hvd_sincos u_sc_dlat (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (sc_ctl),
        .ang     (ang_reg[0]),
        .vld_out (sc_vld),
        .sin_q30 (slat),
        .cos_q30 ()
    );

    hvd_sincos u_sc_dlon (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (sc_ctl),
        .ang     (ang_reg[1]),
        .vld_out (),
        .sin_q30 (slon),
        .cos_q30 ()
    );

    hvd_sincos u_sc_lat1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (sc_ctl),
        .ang     (ang_reg[2]),
        .vld_out (),
        .sin_q30 (),
        .cos_q30 (c1)
    );

    hvd_sincos u_sc_lat2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (sc_ctl),
        .ang     (ang_reg[3]),
        .vld_out (),
        .sin_q30 (),
        .cos_q30 (c2)
    );

    // a = slat^2 + ((c1*c2 >> 30) * slon >> 30) * slon, clamped to [0, 1]
    logic signed [63:0]    cc_reg;
    logic signed [63:0]    sq1_reg, sq2_reg, sq3_reg;
    logic signed [TW-1:0]  slon1_reg, slon2_reg;
    logic signed [63:0]    tp_reg;
    logic signed [63:0]    ts_reg;
    logic [A_W-1:0]        a4_reg, a5_reg, b5_reg;
    logic                  mv1_reg, mv2_reg, mv3_reg, mv4_reg, mv5_reg;

    logic signed [TW-1:0]  cprod;
    logic signed [TW-1:0]  tval;
    logic signed [63:0]    asum;
    logic [A_W-1:0]        a_clamp;

    always_comb
    begin
        cprod = $signed(cc_reg[61:30]);
        tval  = $signed(tp_reg[61:30]);
        asum  = sq3_reg + ts_reg;
        priority if (asum < 0)
            a_clamp = '0;
        else if (asum > hvd_pkg::SUM_ONE)
            a_clamp = hvd_pkg::ONE_Q60;
        else
            a_clamp = asum[A_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cc_reg    <= c1 * c2;
            sq1_reg   <= slat * slat;
            slon1_reg <= slon;

            tp_reg    <= cprod * slon1_reg;
            sq2_reg   <= sq1_reg;
            slon2_reg <= slon1_reg;

            ts_reg    <= tval * slon2_reg;
            sq3_reg   <= sq2_reg;

            a4_reg    <= a_clamp;

            a5_reg    <= a4_reg;
            b5_reg    <= hvd_pkg::ONE_Q60 - a4_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv1_reg <= 1'b0;
            mv2_reg <= 1'b0;
            mv3_reg <= 1'b0;
            mv4_reg <= 1'b0;
            mv5_reg <= 1'b0;
        end
        else if (en)
        begin
            mv1_reg <= sc_vld;
            mv2_reg <= mv1_reg;
            mv3_reg <= mv2_reg;
            mv4_reg <= mv3_reg;
            mv5_reg <= mv4_reg;
        end
    end

    // square roots of a and 1 - a
    hvd_pkg::hvd_ctl_t  sq_ctl;
    logic               sq_vld;
    logic [RT-1:0]      root_a;
    logic [RT-1:0]      root_b;

    assign sq_ctl = '{en: en, vld: mv5_reg};

    hvd_sqrt u_sqrt_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (sq_ctl),
        .radicand (a5_reg),
        .vld_out  (sq_vld),
        .root     (root_a)
    );

    hvd_sqrt u_sqrt_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (sq_ctl),
        .radicand (b5_reg),
        .vld_out  (),
        .root     (root_b)
    );

    // atan2(sqrt(a), sqrt(1-a)) by vectoring CORDIC
    logic signed [CW-1:0] vx_reg [STEPS+1];
    logic signed [CW-1:0] vy_reg [STEPS+1];
    logic signed [CW-1:0] vz_reg [STEPS+1];
    logic                 vv_reg [STEPS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx_reg[0] <= CW'(root_b);
            vy_reg[0] <= CW'(root_a);
            vz_reg[0] <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vv_reg[0] <= 1'b0;
        else if (en)
            vv_reg[0] <= sq_vld;
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_vec
        logic signed [CW-1:0] x_sh;
        logic signed [CW-1:0] y_sh;
        logic signed [CW-1:0] x_nx;
        logic signed [CW-1:0] y_nx;
        logic signed [CW-1:0] z_nx;

        always_comb
        begin
            x_sh = vx_reg[i] >>> i;
            y_sh = vy_reg[i] >>> i;
            priority if (vy_reg[i] > 0)
            begin
                x_nx = vx_reg[i] + y_sh;
                y_nx = vy_reg[i] - x_sh;
                z_nx = vz_reg[i] + hvd_pkg::ATAN_TURN[i];
            end
            else if (vy_reg[i] < 0)
            begin
                x_nx = vx_reg[i] - y_sh;
                y_nx = vy_reg[i] + x_sh;
                z_nx = vz_reg[i] - hvd_pkg::ATAN_TURN[i];
            end
            else
            begin
                x_nx = vx_reg[i];
                y_nx = vy_reg[i];
                z_nx = vz_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                vx_reg[i+1] <= x_nx;
                vy_reg[i+1] <= y_nx;
                vz_reg[i+1] <= z_nx;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vv_reg[i+1] <= 1'b0;
            else if (en)
                vv_reg[i+1] <= vv_reg[i];
        end
    end

    // scale the angle to meters, round and saturate
    logic [RT-1:0]                zc_reg;
    logic [63:0]                  pm_reg;
    logic [hvd_pkg::DIST_W-1:0]   dist_reg;
    logic                         zc_vld_reg;
    logic                         pm_vld_reg;

    logic [RT-1:0]                z_clamp;
    logic [63:0]                  pm_round;
    logic [25:0]                  dist_raw;
    logic [hvd_pkg::DIST_W-1:0]   dist_sat;

    always_comb
    begin
        priority if (vz_reg[STEPS] < 0)
            z_clamp = '0;
        else if (vz_reg[STEPS] > hvd_pkg::ONE_Q30)
            z_clamp = RT'(hvd_pkg::ONE_Q30);
        else
            z_clamp = vz_reg[STEPS][RT-1:0];
        pm_round = pm_reg + hvd_pkg::ROUND_38;
        dist_raw = pm_round[63:38];
        dist_sat = (dist_raw > 26'(hvd_pkg::HALF_CIRC)) ? hvd_pkg::HALF_CIRC
                                                       : dist_raw[hvd_pkg::DIST_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zc_reg   <= z_clamp;
            pm_reg   <= zc_reg * hvd_pkg::PI_R_Q8;
            dist_reg <= dist_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zc_vld_reg  <= 1'b0;
            pm_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            zc_vld_reg  <= vv_reg[STEPS];
            pm_vld_reg  <= zc_vld_reg;
            out_vld_reg <= pm_vld_reg;
        end
    end

    assign distance.valid           = out_vld_reg;
    assign distance.distance_meters = dist_reg;

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        distance.valid |-> distance.distance_meters <= hvd_pkg::HALF_CIRC)
        else $error("distance beyond half circumference");

    a_transfer_enters: assert property (@(posedge clk) disable iff (!rst_n)
        points.valid && points.ready |=> v0_reg)
        else $error("accepted transfer did not enter the pipeline");

    a_unit_sum: assert property (@(posedge clk) disable iff (!rst_n)
        mv5_reg |-> (a5_reg + b5_reg) == hvd_pkg::ONE_Q60)
        else $error("a and 1-a do not sum to one");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v5_reg) && $stable(mv5_reg) && $stable(vv_reg[STEPS]))
        else $error("pipeline moved during a stall");

endmodule
